>>> rtl/ksa_pkg.sv
// Shared types and constants for the keyed stack with search and accumulate.
// Used by ksa_store, ksa_engine and keyed_stack_with_search_accumulate.
// Depends on nothing.
`timescale 1ns / 1ps

package ksa_pkg;

	localparam int DEPTH_DEFAULT = 256;

	// Opcodes of an input item.
	localparam logic [3:0] OP_PUSH     = 4'd0;
	localparam logic [3:0] OP_POP      = 4'd1;
	localparam logic [3:0] OP_READ     = 4'd2;
	localparam logic [3:0] OP_WRITE_ID = 4'd3;
	localparam logic [3:0] OP_WRITE_VAL = 4'd4;
	localparam logic [3:0] OP_FIND_ID  = 4'd5;
	localparam logic [3:0] OP_FIND_VAL = 4'd6;
	localparam logic [3:0] OP_ACCUM    = 4'd7;
	localparam logic [3:0] OP_EMPTY    = 4'd8;
	localparam logic [3:0] OP_SUM      = 4'd9;

	// Result status codes.
	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_NOT_FOUND = 3'd1;
	localparam logic [2:0] STAT_EMPTY     = 3'd2;
	localparam logic [2:0] STAT_FULL      = 3'd3;
	localparam logic [2:0] STAT_NEW       = 3'd4;

	// Configuration register indexes and reset values.
	localparam logic REG_NULL_ID  = 1'b0;
	localparam logic REG_MISS_VAL = 1'b1;
	localparam logic [31:0] NULL_ID_RESET  = 32'hFFFF_FFFF;
	localparam logic [31:0] MISS_VAL_RESET = 32'h0000_0000;

	typedef struct packed {
		logic [3:0]  opcode;
		logic [31:0] key_id;
		logic [31:0] entry_value;
		logic [7:0]  entry_index;
	} ksa_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] found_id;
		logic [31:0] found_value;
		logic [8:0]  entry_count;
	} ksa_res_t;

	// Strobes from the sequencer to the entry store.
	typedef struct packed {
		logic rd_en;
		logic we_id;
		logic we_val;
	} ksa_mem_ctl_t;

endpackage

>>> rtl/ksa_store.sv
// Entry store: the id and value memories, one write and one read port each,
// read data registered. Depends on ksa_pkg.
`timescale 1ns / 1ps

module ksa_store #(
	parameter int DEPTH = ksa_pkg::DEPTH_DEFAULT,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  ksa_pkg::ksa_mem_ctl_t ctl,
	input  logic [AW-1:0]         rd_addr,
	input  logic [AW-1:0]         wr_addr,
	input  logic [31:0]           wr_id,
	input  logic [31:0]           wr_val,
	output logic [31:0]           rd_id,
	output logic [31:0]           rd_val
);

	logic [31:0] id_mem_q  [DEPTH];
	logic [31:0] val_mem_q [DEPTH];
	logic [31:0] rd_id_q;
	logic [31:0] rd_val_q;

	always_ff @(posedge clk) begin
		if (ctl.we_id) begin
			id_mem_q[wr_addr] <= wr_id;
		end
		if (ctl.rd_en) begin
			rd_id_q <= id_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.we_val) begin
			val_mem_q[wr_addr] <= wr_val;
		end
		if (ctl.rd_en) begin
			rd_val_q <= val_mem_q[rd_addr];
		end
	end

	assign rd_id  = rd_id_q;
	assign rd_val = rd_val_q;

endmodule

>>> rtl/ksa_engine.sv
// Sequencer: decodes one item at a time, walks the entry store for searches,
// accumulate and sum, and holds the entry count. Depends on ksa_pkg.
`timescale 1ns / 1ps

module ksa_engine #(
	parameter int DEPTH = ksa_pkg::DEPTH_DEFAULT,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ksa_pkg::ksa_in_t      in_item,
	input  logic [31:0]           null_id,
	input  logic [31:0]           miss_val,
	output logic                  res_valid,
	input  logic                  res_ready,
	output ksa_pkg::ksa_res_t     res,
	output ksa_pkg::ksa_mem_ctl_t mem_ctl,
	output logic [AW-1:0]         rd_addr,
	output logic [AW-1:0]         wr_addr,
	output logic [31:0]           wr_id,
	output logic [31:0]           wr_val,
	input  logic [31:0]           rd_id,
	input  logic [31:0]           rd_val
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > 8) ? CW : 8;
	localparam int SW   = 32 + CW;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_RDWAIT,
		S_SCAN,
		S_ACC_WR,
		S_ACC_NEW,
		S_SUM_FIN,
		S_DONE
	} state_t;

	state_t                 state_q;
	logic [3:0]             op_q;
	logic [31:0]            kid_q;
	logic [31:0]            kval_q;
	logic [7:0]             idx_q;
	logic [CW-1:0]          count_q;
	logic [2:0]             stat_q;
	logic [31:0]            fid_q;
	logic [31:0]            fval_q;
	logic [CW-1:0]          ptr_q;
	logic [CW-1:0]          cmp_s1;
	logic                   rvld_s1;
	logic signed [SW-1:0]   sum_q;
	logic [31:0]            hit_val_q;
	logic [AW-1:0]          hit_idx_q;

	logic          full;
	logic          empty;
	logic          in_range;
	logic [AW-1:0] idx_addr;
	logic          scan_rd;
	logic          match;
	logic          last;
	logic [32:0]   acc_sum;
	logic [31:0]   acc_sat;
	logic [31:0]   sum_sat;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign in_range = (CMPW'(idx_q) < CMPW'(count_q));
	assign idx_addr = AW'(CMPW'(idx_q));
	assign scan_rd  = (ptr_q < count_q);

	// Searches by id for find-by-id and accumulate, by value for find-by-value.
	always_comb begin
		if (op_q == ksa_pkg::OP_FIND_VAL) begin
			match = rvld_s1 && (rd_val == kval_q);
		end else begin
			match = rvld_s1 && (rd_id == kid_q);
		end
	end
	assign last = rvld_s1 && (cmp_s1 == count_q - CW'(1));

	// Saturating add for accumulate into a matching entry.
	assign acc_sum = {hit_val_q[31], hit_val_q} + {kval_q[31], kval_q};
	always_comb begin
		if (acc_sum[32] == acc_sum[31]) begin
			acc_sat = acc_sum[31:0];
		end else if (acc_sum[32]) begin
			acc_sat = 32'h8000_0000;
		end else begin
			acc_sat = 32'h7FFF_FFFF;
		end
	end

	// The sum is exact; it fits 32 bits only when the top bits all agree.
	always_comb begin
		if ((&sum_q[SW-1:31]) || !(|sum_q[SW-1:31])) begin
			sum_sat = sum_q[31:0];
		end else if (sum_q[SW-1]) begin
			sum_sat = 32'h8000_0000;
		end else begin
			sum_sat = 32'h7FFF_FFFF;
		end
	end

	always_comb begin
		mem_ctl = '0;
		rd_addr = AW'(ptr_q);
		wr_addr = AW'(count_q);
		wr_id   = kid_q;
		wr_val  = kval_q;
		case (state_q)
			S_DISPATCH: begin
				case (op_q)
					ksa_pkg::OP_PUSH: begin
						mem_ctl.we_id  = !full;
						mem_ctl.we_val = !full;
					end
					ksa_pkg::OP_POP: begin
						mem_ctl.rd_en = !empty;
						rd_addr       = AW'(count_q - CW'(1));
					end
					ksa_pkg::OP_READ: begin
						mem_ctl.rd_en = in_range;
						rd_addr       = idx_addr;
					end
					ksa_pkg::OP_WRITE_ID: begin
						mem_ctl.we_id = in_range;
						wr_addr       = idx_addr;
					end
					ksa_pkg::OP_WRITE_VAL: begin
						mem_ctl.we_val = in_range;
						wr_addr        = idx_addr;
					end
					default: begin
					end
				endcase
			end
			S_SCAN: begin
				mem_ctl.rd_en = scan_rd;
			end
			S_ACC_WR: begin
				mem_ctl.we_val = 1'b1;
				wr_addr        = hit_idx_q;
				wr_val         = acc_sat;
			end
			S_ACC_NEW: begin
				mem_ctl.we_id  = !full;
				mem_ctl.we_val = !full;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= in_item.opcode;
						kid_q   <= in_item.key_id;
						kval_q  <= in_item.entry_value;
						idx_q   <= in_item.entry_index;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					stat_q  <= ksa_pkg::STAT_OK;
					fid_q   <= '0;
					fval_q  <= '0;
					ptr_q   <= '0;
					rvld_s1 <= 1'b0;
					sum_q   <= '0;
					state_q <= S_DONE;
					case (op_q)
						ksa_pkg::OP_PUSH: begin
							if (full) begin
								stat_q <= ksa_pkg::STAT_FULL;
							end else begin
								count_q <= count_q + CW'(1);
							end
						end
						ksa_pkg::OP_POP: begin
							if (empty) begin
								stat_q <= ksa_pkg::STAT_EMPTY;
								fid_q  <= null_id;
								fval_q <= miss_val;
							end else begin
								count_q <= count_q - CW'(1);
								state_q <= S_RDWAIT;
							end
						end
						ksa_pkg::OP_READ: begin
							if (in_range) begin
								state_q <= S_RDWAIT;
							end else begin
								stat_q <= ksa_pkg::STAT_NOT_FOUND;
								fid_q  <= null_id;
								fval_q <= miss_val;
							end
						end
						ksa_pkg::OP_WRITE_ID, ksa_pkg::OP_WRITE_VAL: begin
							if (!in_range) begin
								stat_q <= ksa_pkg::STAT_NOT_FOUND;
							end
						end
						ksa_pkg::OP_FIND_ID: begin
							if (empty) begin
								stat_q <= ksa_pkg::STAT_NOT_FOUND;
								fval_q <= miss_val;
							end else begin
								state_q <= S_SCAN;
							end
						end
						ksa_pkg::OP_FIND_VAL: begin
							if (empty) begin
								stat_q <= ksa_pkg::STAT_NOT_FOUND;
								fid_q  <= null_id;
							end else begin
								state_q <= S_SCAN;
							end
						end
						ksa_pkg::OP_ACCUM: begin
							state_q <= empty ? S_ACC_NEW : S_SCAN;
						end
						ksa_pkg::OP_EMPTY: begin
							count_q <= '0;
						end
						ksa_pkg::OP_SUM: begin
							if (empty) begin
								stat_q <= ksa_pkg::STAT_EMPTY;
								fval_q <= miss_val;
							end else begin
								state_q <= S_SCAN;
							end
						end
						default: begin
							stat_q <= ksa_pkg::STAT_NOT_FOUND;
						end
					endcase
				end
				S_RDWAIT: begin
					fid_q   <= rd_id;
					fval_q  <= rd_val;
					state_q <= S_DONE;
				end
				S_SCAN: begin
					// One read is issued per cycle; its data is checked in the cycle after.
					rvld_s1 <= scan_rd;
					cmp_s1  <= ptr_q;
					if (scan_rd) begin
						ptr_q <= ptr_q + CW'(1);
					end
					if (op_q == ksa_pkg::OP_SUM) begin
						if (rvld_s1) begin
							sum_q <= sum_q + SW'(signed'(rd_val));
							if (last) begin
								state_q <= S_SUM_FIN;
							end
						end
					end else if (match) begin
						case (op_q)
							ksa_pkg::OP_FIND_ID: begin
								fval_q  <= rd_val;
								state_q <= S_DONE;
							end
							ksa_pkg::OP_FIND_VAL: begin
								fid_q   <= rd_id;
								state_q <= S_DONE;
							end
							default: begin
								hit_val_q <= rd_val;
								hit_idx_q <= AW'(cmp_s1);
								state_q   <= S_ACC_WR;
							end
						endcase
					end else if (last) begin
						case (op_q)
							ksa_pkg::OP_FIND_ID: begin
								stat_q  <= ksa_pkg::STAT_NOT_FOUND;
								fval_q  <= miss_val;
								state_q <= S_DONE;
							end
							ksa_pkg::OP_FIND_VAL: begin
								stat_q  <= ksa_pkg::STAT_NOT_FOUND;
								fid_q   <= null_id;
								state_q <= S_DONE;
							end
							default: begin
								state_q <= S_ACC_NEW;
							end
						endcase
					end
				end
				S_ACC_WR: begin
					fval_q  <= acc_sat;
					state_q <= S_DONE;
				end
				S_ACC_NEW: begin
					if (full) begin
						stat_q <= ksa_pkg::STAT_FULL;
					end else begin
						stat_q  <= ksa_pkg::STAT_NEW;
						fval_q  <= kval_q;
						count_q <= count_q + CW'(1);
					end
					state_q <= S_DONE;
				end
				S_SUM_FIN: begin
					fval_q  <= sum_sat;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res.status      = stat_q;
	assign res.found_id    = fid_q;
	assign res.found_value = fval_q;
	assign res.entry_count = 9'(count_q);

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_DISPATCH)
		else $error("accepted item did not reach dispatch");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN && rvld_s1 |-> cmp_s1 < count_q)
		else $error("scan compared an entry above the count");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_ctl.we_id || mem_ctl.we_val) |-> CW'(wr_addr) <= count_q && !full
			|| CW'(wr_addr) < count_q)
		else $error("store written beyond the top entry");

	a_sum_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SUM_FIN |-> $past(state_q) == S_SCAN && op_q == ksa_pkg::OP_SUM)
		else $error("sum finished without a scan");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && !res_ready |=> state_q == S_DONE && $stable(fval_q))
		else $error("result dropped while stalled");

endmodule

>>> rtl/keyed_stack_with_search_accumulate.sv
// Top level of the keyed stack: configuration registers, output register and
// the sequencer and entry store. Depends on ksa_pkg, ksa_store and ksa_engine.
`timescale 1ns / 1ps

// A bounded stack of (id, value) entries with linear search, saturating
// accumulate and sum. Commands arrive on the s_ group: the opcode in s_tuser,
// the operands in s_tdata. Each command gives exactly one result on the m_
// group: the status in m_tuser, the found id, found value and entry count in
// m_tdata.
// Items are handled one at a time. Push, write, empty and unknown opcodes, and
// a pop or read that finds nothing, go from dispatch straight to the result;
// a pop or read that returns an entry first waits for the registered store
// read. Find, accumulate and sum walk the store at one entry read per cycle,
// as the store has a single read port.
// The output register holds a finished result while the receiver stalls, so
// the next command is taken in meanwhile; a further result then waits in the
// sequencer and s_tready stays low until the output register frees.
// Reset clears the entry count, the null id to all ones and the null value to
// zero; the store itself needs no clearing. Configuration writes through
// cfg_we are meant only while the block is idle.
module keyed_stack_with_search_accumulate #(
	parameter int DEPTH = ksa_pkg::DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // key_id[31:0], entry_value[63:32], entry_index[71:64]
	input  logic [3:0]  s_tuser,   // opcode[3:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // found_id[31:0], found_value[63:32],
	                               // entry_count[72:64], zero[79:73]
	output logic [2:0]  m_tuser    // status[2:0]
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [31:0]           null_id_q;
	logic [31:0]           miss_val_q;
	ksa_pkg::ksa_in_t      in_item;
	ksa_pkg::ksa_res_t     res;
	ksa_pkg::ksa_res_t     res_q;
	logic                  res_valid;
	logic                  res_ready;
	logic                  m_tvalid_q;
	ksa_pkg::ksa_mem_ctl_t mem_ctl;
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         wr_addr;
	logic [31:0]           wr_id;
	logic [31:0]           wr_val;
	logic [31:0]           rd_id;
	logic [31:0]           rd_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			null_id_q  <= ksa_pkg::NULL_ID_RESET;
			miss_val_q <= ksa_pkg::MISS_VAL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ksa_pkg::REG_NULL_ID:  null_id_q  <= cfg_wdata;
				ksa_pkg::REG_MISS_VAL: miss_val_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign in_item.opcode      = s_tuser;
	assign in_item.key_id      = s_tdata[31:0];
	assign in_item.entry_value = s_tdata[63:32];
	assign in_item.entry_index = s_tdata[71:64];

	ksa_engine #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.null_id  (null_id_q),
		.miss_val (miss_val_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.mem_ctl  (mem_ctl),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr),
		.wr_id    (wr_id),
		.wr_val   (wr_val),
		.rd_id    (rd_id),
		.rd_val   (rd_val)
	);

	ksa_store #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.ctl    (mem_ctl),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr),
		.wr_id  (wr_id),
		.wr_val (wr_val),
		.rd_id  (rd_id),
		.rd_val (rd_val)
	);

	// The output register takes a new result whenever it is empty or its
	// current one is transferred in the same cycle.
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = res_q.status;
	assign m_tdata  = {7'b0, res_q.entry_count, res_q.found_value, res_q.found_id};

endmodule

>>> tb/sv/ksa_stack_checker.sv
// Checker for the keyed stack: follows configuration writes and command transfers,
// predicts each result and compares it with the result stream.
// Depends on ksa_pkg for the opcode, status and record types.
`timescale 1ns / 1ps

module ksa_stack_checker #(
	parameter int DEPTH = ksa_pkg::DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,   // key_id[31:0], entry_value[63:32], entry_index[71:64]
	input  logic [3:0]  s_tuser,   // opcode[3:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [79:0] m_tdata,   // found_id[31:0], found_value[63:32],
	                               // entry_count[72:64], zero[79:73]
	input  logic [2:0]  m_tuser,   // status[2:0]
	output int          fail_count,
	output int          results_pending
);

	import ksa_pkg::*;

	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;

	logic [31:0]  id_mem  [DEPTH];
	logic [31:0]  val_mem [DEPTH];
	int unsigned  depth_used;
	logic [31:0]  null_id;
	logic [31:0]  miss_val;
	ksa_res_t     results_due [$];

	function automatic logic [31:0] sat_q16(input longint s);
		if (s > Q_MAX)
			return 32'h7FFF_FFFF;
		if (s < Q_MIN)
			return 32'h8000_0000;
		return s[31:0];
	endfunction

	// Applies one command to the local copy of the stack and returns its result.
	function automatic ksa_res_t stack_step(input ksa_in_t c);
		ksa_res_t    r;
		int unsigned i;
		bit          hit;
		longint      total;
		r = '0;
		hit = 1'b0;
		total = 0;
		case (c.opcode)
			OP_PUSH: begin
				if (depth_used >= DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					id_mem[depth_used] = c.key_id;
					val_mem[depth_used] = c.entry_value;
					depth_used++;
				end
			end
			OP_POP: begin
				if (depth_used == 0) begin
					r.status = STAT_EMPTY;
					r.found_id = null_id;
					r.found_value = miss_val;
				end else begin
					depth_used--;
					r.found_id = id_mem[depth_used];
					r.found_value = val_mem[depth_used];
				end
			end
			OP_READ: begin
				if (c.entry_index < depth_used) begin
					r.found_id = id_mem[c.entry_index];
					r.found_value = val_mem[c.entry_index];
				end else begin
					r.status = STAT_NOT_FOUND;
					r.found_id = null_id;
					r.found_value = miss_val;
				end
			end
			OP_WRITE_ID, OP_WRITE_VAL: begin
				if (c.entry_index >= depth_used)
					r.status = STAT_NOT_FOUND;
				else if (c.opcode == OP_WRITE_ID)
					id_mem[c.entry_index] = c.key_id;
				else
					val_mem[c.entry_index] = c.entry_value;
			end
			OP_FIND_ID: begin
				for (i = 0; i < depth_used && !hit; i++)
					if (id_mem[i] == c.key_id) begin
						r.found_value = val_mem[i];
						hit = 1'b1;
					end
				if (!hit) begin
					r.status = STAT_NOT_FOUND;
					r.found_value = miss_val;
				end
			end
			OP_FIND_VAL: begin
				for (i = 0; i < depth_used && !hit; i++)
					if (val_mem[i] == c.entry_value) begin
						r.found_id = id_mem[i];
						hit = 1'b1;
					end
				if (!hit) begin
					r.status = STAT_NOT_FOUND;
					r.found_id = null_id;
				end
			end
			OP_ACCUM: begin
				for (i = 0; i < depth_used && !hit; i++)
					if (id_mem[i] == c.key_id) begin
						val_mem[i] = sat_q16(longint'($signed(val_mem[i]))
							+ longint'($signed(c.entry_value)));
						r.found_value = val_mem[i];
						hit = 1'b1;
					end
				if (!hit) begin
					if (depth_used >= DEPTH) begin
						r.status = STAT_FULL;
					end else begin
						id_mem[depth_used] = c.key_id;
						val_mem[depth_used] = c.entry_value;
						depth_used++;
						r.status = STAT_NEW;
						r.found_value = c.entry_value;
					end
				end
			end
			OP_EMPTY: depth_used = 0;
			OP_SUM: begin
				if (depth_used == 0) begin
					r.status = STAT_EMPTY;
					r.found_value = miss_val;
				end else begin
					// The sum is kept exact and saturated only once at the end.
					for (i = 0; i < depth_used; i++)
						total += longint'($signed(val_mem[i]));
					r.found_value = sat_q16(total);
				end
			end
			default: r.status = STAT_NOT_FOUND;
		endcase
		r.entry_count = depth_used[8:0];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got, inout int bad);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			bad++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		ksa_in_t  cmd;
		ksa_res_t want;
		int       bad;
		bad = 0;
		if (!arst_n) begin
			depth_used = 0;
			null_id = NULL_ID_RESET;
			miss_val = MISS_VAL_RESET;
			results_due.delete();
			fail_count <= 0;
			results_pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_NULL_ID)
					null_id = cfg_wdata;
				else
					miss_val = cfg_wdata;
			end
			// The result side is handled first, as a result can never belong to
			// the command taken in at the same edge.
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					$error("result transfer with no command outstanding");
					bad++;
				end else begin
					want = results_due.pop_front();
					check_field("status", 32'(want.status), 32'(m_tuser), bad);
					check_field("found_id", want.found_id, m_tdata[31:0], bad);
					check_field("found_value", want.found_value, m_tdata[63:32], bad);
					check_field("entry_count", 32'(want.entry_count),
						32'(m_tdata[72:64]), bad);
					check_field("padding", 32'd0, 32'(m_tdata[79:73]), bad);
				end
			end
			if (s_tvalid && s_tready) begin
				cmd.opcode = s_tuser;
				cmd.key_id = s_tdata[31:0];
				cmd.entry_value = s_tdata[63:32];
				cmd.entry_index = s_tdata[71:64];
				results_due.push_back(stack_step(cmd));
			end
			fail_count <= fail_count + bad;
			results_pending <= results_due.size();
		end
	end

endmodule

>>> tb/sv/keyed_stack_with_search_accumulate_tb.sv
// Top of the keyed stack testbench: clock, reset, command and configuration
// stimulus, result-side back-pressure and the verdict.
// Depends on ksa_pkg, keyed_stack_with_search_accumulate and ksa_stack_checker.
`timescale 1ns / 1ps

module keyed_stack_with_search_accumulate_tb;

	import ksa_pkg::*;

	localparam logic [3:0] OP_UNUSED_LO = 4'd10;
	localparam logic [3:0] OP_UNUSED_HI = 4'd15;
	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_ITEMS   = 70;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_NULL_ID;
	logic [31:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;   // key_id[31:0], entry_value[63:32], entry_index[71:64]
	logic [3:0]  s_tuser = OP_PUSH;   // opcode[3:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;        // found_id[31:0], found_value[63:32],
	                             // entry_count[72:64], zero[79:73]
	logic [2:0]  m_tuser;        // status[2:0]

	int fail_count;
	int results_pending;
	int cycle_count = 0;
	bit steady = 1'b0;
	bit hold_rx = 1'b0;

	keyed_stack_with_search_accumulate DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	ksa_stack_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fail_count(fail_count), .results_pending(results_pending)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("keyed_stack_with_search_accumulate_tb: errors");
			$finish;
		end
	end

	// Mostly a small set of ids and values so that searches and accumulates hit.
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 11))
			0: return 32'h0000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h0001_0000;
			4: return 32'hFFFF_0000;
			5: return 32'h4000_0000;
			6: return 32'hC000_0000;
			7: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	task automatic issue(input logic [3:0] op, input logic [31:0] kid,
			input logic [31:0] val, input logic [7:0] idx);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {idx, val, kid};
		do @(posedge clk); while (!s_tready);
	endtask

	// The checker's count is registered, hence the first wait.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0)
			@(posedge clk);
	endtask

	// The write enable is dropped between writes so that back-to-back writes
	// never drive it twice at one edge.
	task automatic write_reg(input logic idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : receiver
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 8);
			if (hold_rx) begin
				hold_rx = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid && !hold_rx);
		end
	end

	initial begin : stimulus
		logic [3:0]  op;
		logic [31:0] kid;
		logic [31:0] last_id;
		logic [7:0]  idx;
		int          roll;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset values of the null registers.
		issue(OP_POP, 32'h0, 32'h0, 8'd0);
		issue(OP_SUM, 32'h0, 32'h0, 8'd0);
		issue(OP_READ, 32'h0, 32'h0, 8'd0);
		issue(OP_FIND_ID, 32'h0000_1234, 32'h0, 8'd0);
		issue(OP_FIND_VAL, 32'h0, 32'h0, 8'd0);
		issue(OP_WRITE_VAL, 32'h0, 32'h1, 8'd0);
		issue(OP_PUSH, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd255);
		issue(OP_PUSH, 32'h8000_0000, 32'h8000_0000, 8'd0);
		issue(OP_PUSH, 32'h7FFF_FFFF, 32'h0001_0000, 8'd0);
		issue(OP_ACCUM, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd0);
		issue(OP_ACCUM, 32'h8000_0000, 32'h8000_0000, 8'd0);
		issue(OP_ACCUM, 32'h0000_0000, 32'hFFFF_0000, 8'd0);
		issue(OP_FIND_ID, 32'h7FFF_FFFF, 32'h0, 8'd0);
		issue(OP_FIND_VAL, 32'h0, 32'h0001_0000, 8'd0);
		issue(OP_READ, 32'h0, 32'h0, 8'd2);
		issue(OP_READ, 32'h0, 32'h0, 8'd255);
		issue(OP_WRITE_ID, 32'hDEAD_BEEF, 32'h0, 8'd1);
		issue(OP_WRITE_VAL, 32'h0, 32'h7FFF_FFFF, 8'd3);
		issue(OP_SUM, 32'h0, 32'h0, 8'd0);
		issue(OP_UNUSED_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
		issue(OP_UNUSED_HI, 32'h0, 32'h0, 8'd0);
		issue(OP_POP, 32'h0, 32'h0, 8'd0);
		issue(OP_EMPTY, 32'h0, 32'h0, 8'd0);
		issue(OP_POP, 32'h0, 32'h0, 8'd0);
		issue(OP_PUSH, 32'h0, 32'h0, 8'd0);

		// Fill the stack to the top, then probe the full cases and a full-length walk.
		wait_drained();
		write_reg(REG_NULL_ID, 32'h8000_0000);
		write_reg(REG_MISS_VAL, 32'h7FFF_FFFF);
		issue(OP_EMPTY, 32'h0, 32'h0, 8'd0);
		last_id = '0;
		repeat (DEPTH_DEFAULT) begin
			last_id = $urandom();
			issue(OP_PUSH, last_id, $urandom(), 8'($urandom()));
		end
		issue(OP_PUSH, 32'h1, 32'h1, 8'd0);
		issue(OP_ACCUM, 32'h5A5A_0001, 32'h1, 8'd0);
		issue(OP_ACCUM, last_id, 32'h7FFF_FFFF, 8'd0);
		issue(OP_SUM, 32'h0, 32'h0, 8'd0);
		issue(OP_FIND_ID, 32'h5A5A_0001, 32'h0, 8'd0);
		issue(OP_READ, 32'h0, 32'h0, 8'd255);
		issue(OP_WRITE_ID, 32'h0123_4567, 32'h0, 8'd255);
		issue(OP_POP, 32'h0, 32'h0, 8'd0);
		issue(OP_EMPTY, 32'h0, 32'h0, 8'd0);

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_drained();
			case (phase)
				0: begin
					write_reg(REG_NULL_ID, 32'h7FFF_FFFF);
					write_reg(REG_MISS_VAL, 32'h8000_0000);
				end
				1: begin
					write_reg(REG_NULL_ID, 32'h0000_0000);
					write_reg(REG_MISS_VAL, 32'hFFFF_FFFF);
				end
				default: begin
					write_reg(REG_NULL_ID, $urandom());
					write_reg(REG_MISS_VAL, $urandom());
				end
			endcase
			steady = (phase == 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 1 && n == 60)
					wait_drained();
				if (phase == 2 && n == 40) begin
					// Long receiver hold-off while commands keep coming back to back.
					hold_rx = 1'b1;
					steady = 1'b1;
					repeat (12)
						issue(OP_READ, $urandom(), $urandom(), 8'($urandom_range(0, 8)));
					steady = 1'b0;
				end
				roll = $urandom_range(0, 99);
				if (roll < 20)
					op = OP_PUSH;
				else if (roll < 32)
					op = OP_POP;
				else if (roll < 44)
					op = OP_READ;
				else if (roll < 51)
					op = OP_WRITE_ID;
				else if (roll < 58)
					op = OP_WRITE_VAL;
				else if (roll < 68)
					op = OP_FIND_ID;
				else if (roll < 78)
					op = OP_FIND_VAL;
				else if (roll < 92)
					op = OP_ACCUM;
				else if (roll < 94)
					op = OP_EMPTY;
				else if (roll < 98)
					op = OP_SUM;
				else
					op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
				kid = pick_word();
				idx = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
					: 8'($urandom_range(0, 40));
				issue(op, kid, pick_word(), idx);
			end
		end
		steady = 1'b0;

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("keyed_stack_with_search_accumulate_tb: clean");
		else
			$display("keyed_stack_with_search_accumulate_tb: errors");
		$finish;
	end

endmodule
